// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK_NORST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// File: rtl/mep_pkg.sv
// types and constants of the mandelbrot escape-time pixel engine
`default_nettype none

package mep_pkg;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int COORD_REG_BITS = 32;
   localparam int COLOR_BITS = 32;
   localparam int CHAN_BITS = 8;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_X_START = 3'd0,
      CSR_X_STEP  = 3'd1,
      CSR_Y_START = 3'd2,
      CSR_Y_STEP  = 3'd3,
      CSR_ITER_CAP = 3'd4
   } csr_index_type;

   localparam logic [COORD_REG_BITS-1:0] X_START_RST = 32'hE900_0000;
   localparam logic [COORD_REG_BITS-1:0] X_STEP_RST  = 32'd353205;
   localparam logic [COORD_REG_BITS-1:0] Y_START_RST = 32'hF600_0000;
   localparam logic [COORD_REG_BITS-1:0] Y_STEP_RST  = 32'd335544;
   localparam int ITER_CAP_RST = 75;

   localparam logic [COORD_REG_BITS-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_REG_BITS-1:0] SAT_MIN = 32'h8000_0000;
   localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_MAP_MUL = 7'b0000010,
      ST_MAP_ADD = 7'b0000100,
      ST_SQUARE  = 7'b0001000,
      ST_STEP    = 7'b0010000,
      ST_DIV     = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic map_mul;
      logic map_add;
      logic square;
      logic step;
      logic div_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic iter_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/mandelbrot_escape_time_pixel.sv
// top level of the mandelbrot escape-time pixel engine
// one pixel at a time: a word is accepted only while the controller is idle
// each iteration passes through the square multipliers and then the update and
// bailout adders
// the next word is taken while a result waits in the output register
// reset: synchronous; clears control state and loads the register defaults
`default_nettype none

module mandelbrot_escape_time_pixel
   import mep_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS = 27,
   parameter int ITER_BITS = 10,
   localparam int IN_TW = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int OUT_W = 2 * COORD_BITS + ITER_BITS + 1 + COLOR_BITS,
   localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // pixel_x, pixel_y
   input  wire logic [IN_TW-1:0]         req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // out_x, out_y, iterations, inside_res, pixel_color
   output logic      [OUT_TW-1:0]        rsp_tdata,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic [COORD_REG_BITS-1:0] x_start_ff, x_step_ff, y_start_ff, y_step_ff;
   logic [ITER_BITS-1:0] iter_cap_ff;
   cmd_type cmd;
   status_type status;
   logic [COORD_BITS-1:0] out_x, out_y;
   logic [ITER_BITS-1:0] iterations;
   logic inside_res;
   logic [COLOR_BITS-1:0] pixel_color;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff <= X_START_RST;
         x_step_ff <= X_STEP_RST;
         y_start_ff <= Y_START_RST;
         y_step_ff <= Y_STEP_RST;
         iter_cap_ff <= ITER_BITS'(ITER_CAP_RST);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_X_START: x_start_ff <= csr_wdata;
            CSR_X_STEP: x_step_ff <= csr_wdata;
            CSR_Y_START: y_start_ff <= csr_wdata;
            CSR_Y_STEP: y_step_ff <= csr_wdata;
            CSR_ITER_CAP: iter_cap_ff <= csr_wdata[ITER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   mep_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .cmd(cmd),
      .status(status)
   );

   mep_datapath #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS(FRAC_BITS),
      .ITER_BITS(ITER_BITS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .pixel_x(req_tdata[COORD_BITS-1:0]),
      .pixel_y(req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .x_start(x_start_ff),
      .x_step(x_step_ff),
      .y_start(y_start_ff),
      .y_step(y_step_ff),
      .iter_cap(iter_cap_ff),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .out_x(out_x),
      .out_y(out_y),
      .iterations(iterations),
      .inside_res(inside_res),
      .pixel_color(pixel_color)
   );

   assign rsp_tdata = OUT_TW'({pixel_color, inside_res, iterations, out_y, out_x});

endmodule

`default_nettype wire

// File: rtl/mep_divider.sv
// two-lane restoring divider, one quotient bit per cycle, 8-bit quotients
`default_nettype none

module mep_divider
   import mep_pkg::*;
#(
   parameter int DW = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DW-1:0]        num_a,
   input  wire logic [DW-1:0]        den_a,
   input  wire logic [DW-1:0]        num_b,
   input  wire logic [DW-1:0]        den_b,
   output logic      [CHAN_BITS-1:0] quo_a,
   output logic      [CHAN_BITS-1:0] quo_b,
   output logic                      done
);

   localparam int SW = DW + CHAN_BITS - 1;
   localparam int CW = $clog2(CHAN_BITS);

   logic [DW-1:0] rem_a_ff, rem_a_in, rem_b_ff, rem_b_in;
   logic [SW-1:0] dsh_a_ff, dsh_a_in, dsh_b_ff, dsh_b_in;
   logic [CHAN_BITS-1:0] quo_a_ff, quo_a_in, quo_b_ff, quo_b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic ge_a, ge_b;

   assign ge_a = {{(SW-DW){1'b0}}, rem_a_ff} >= dsh_a_ff;
   assign ge_b = {{(SW-DW){1'b0}}, rem_b_ff} >= dsh_b_ff;

   always_comb begin
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      dsh_a_in = dsh_a_ff;
      dsh_b_in = dsh_b_ff;
      quo_a_in = quo_a_ff;
      quo_b_in = quo_b_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_a_in = num_a;
         rem_b_in = num_b;
         dsh_a_in = {den_a, {(CHAN_BITS-1){1'b0}}};
         dsh_b_in = {den_b, {(CHAN_BITS-1){1'b0}}};
         quo_a_in = '0;
         quo_b_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge_a) begin
            rem_a_in = rem_a_ff - dsh_a_ff[DW-1:0];
         end
         if (ge_b) begin
            rem_b_in = rem_b_ff - dsh_b_ff[DW-1:0];
         end
         quo_a_in = {quo_a_ff[CHAN_BITS-2:0], ge_a};
         quo_b_in = {quo_b_ff[CHAN_BITS-2:0], ge_b};
         dsh_a_in = dsh_a_ff >> 1;
         dsh_b_in = dsh_b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(CHAN_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      dsh_a_ff <= dsh_a_in;
      dsh_b_ff <= dsh_b_in;
      quo_a_ff <= quo_a_in;
      quo_b_ff <= quo_b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo_a = quo_a_ff;
   assign quo_b = quo_b_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: rtl/mep_datapath.sv
// datapath: coordinate mapping, z iteration, colour and output register
`default_nettype none

module mep_datapath
   import mep_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS = 27,
   parameter int ITER_BITS = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output status_type                     status,
   input  wire logic [COORD_BITS-1:0]     pixel_x,
   input  wire logic [COORD_BITS-1:0]     pixel_y,
   input  wire logic [COORD_REG_BITS-1:0] x_start,
   input  wire logic [COORD_REG_BITS-1:0] x_step,
   input  wire logic [COORD_REG_BITS-1:0] y_start,
   input  wire logic [COORD_REG_BITS-1:0] y_step,
   input  wire logic [ITER_BITS-1:0]      iter_cap,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic      [COORD_BITS-1:0]     out_x,
   output logic      [COORD_BITS-1:0]     out_y,
   output logic      [ITER_BITS-1:0]      iterations,
   output logic                           inside_res,
   output logic      [COLOR_BITS-1:0]     pixel_color
);

   localparam int ZW = ((FRAC_BITS + 3 > COORD_REG_BITS) ?
                        FRAC_BITS + 3 : COORD_REG_BITS) + 1;
   localparam int PW = 2 * ZW;
   localparam int MW = COORD_REG_BITS + COORD_BITS + 1;
   localparam int DW = ITER_BITS + 10;
   localparam logic signed [PW:0] BAIL =
      {{(PW-2-FRAC_BITS){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic signed [MW-1:0] mx_ff, my_ff, mx_in, my_in;
   logic [COORD_REG_BITS-1:0] cr_ff, ci_ff, cr_in, ci_in;
   logic signed [ZW-1:0] zr_ff, zi_ff, zr_in, zi_in;
   logic signed [PW-1:0] srr_ff, sii_ff, sri_ff;
   logic signed [PW-1:0] p_rr, p_ii, p_ri, cr_ext, ci_ext, nr_full, ni_full;
   logic signed [PW:0] sum_sq;
   logic [ITER_BITS-1:0] iter_ff, iter_in;
   logic inside_ff;
   logic [DW-1:0] iter_ext, max_ext, four_i, gb_diff, num_red, num_gb;
   logic [CHAN_BITS-1:0] red, gb;
   logic div_done;
   logic rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic [ITER_BITS-1:0] iter_out_ff;
   logic inside_out_ff;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   function automatic logic [COORD_REG_BITS-1:0] sat32(input logic signed [MW:0] v);
      logic [MW-COORD_REG_BITS+1:0] top;
      begin
         top = v[MW:COORD_REG_BITS-1];
         if (top == '0 || top == '1) begin
            sat32 = v[COORD_REG_BITS-1:0];
         end else if (v[MW]) begin
            sat32 = SAT_MIN;
         end else begin
            sat32 = SAT_MAX;
         end
      end
   endfunction

   // coordinate mapping
   assign mx_in = MW'($signed(x_step)) * MW'($signed({1'b0, px_ff}));
   assign my_in = MW'($signed(y_step)) * MW'($signed({1'b0, py_ff}));
   assign cr_in = sat32($signed({{(MW-COORD_REG_BITS+1){x_start[COORD_REG_BITS-1]}}, x_start})
                        + $signed({mx_ff[MW-1], mx_ff}));
   assign ci_in = sat32($signed({{(MW-COORD_REG_BITS+1){y_start[COORD_REG_BITS-1]}}, y_start})
                        + $signed({my_ff[MW-1], my_ff}));

   // squares and cross product, floored
   assign p_rr = PW'(zr_ff) * PW'(zr_ff);
   assign p_ii = PW'(zi_ff) * PW'(zi_ff);
   assign p_ri = PW'(zr_ff) * PW'(zi_ff);

   // update and bailout from registered products
   assign cr_ext = $signed({{(PW-COORD_REG_BITS){cr_ff[COORD_REG_BITS-1]}}, cr_ff});
   assign ci_ext = $signed({{(PW-COORD_REG_BITS){ci_ff[COORD_REG_BITS-1]}}, ci_ff});
   assign nr_full = srr_ff - sii_ff + cr_ext;
   assign ni_full = (sri_ff <<< 1) + ci_ext;
   assign sum_sq = {srr_ff[PW-1], srr_ff} + {sii_ff[PW-1], sii_ff};

   always_comb begin
      zr_in = zr_ff;
      zi_in = zi_ff;
      iter_in = iter_ff;
      if (cmd.map_add) begin
         zr_in = '0;
         zi_in = '0;
         iter_in = '0;
      end else if (cmd.step) begin
         zr_in = nr_full[ZW-1:0];
         zi_in = ni_full[ZW-1:0];
         iter_in = iter_ff + 1'b1;
      end
   end

   // colour dividends
   assign iter_ext = {{(DW-ITER_BITS){1'b0}}, iter_ff};
   assign max_ext = {{(DW-ITER_BITS){1'b0}}, iter_cap};
   assign four_i = iter_ext << 2;
   assign gb_diff = four_i - max_ext;
   assign num_red = (iter_ext << CHAN_BITS) - iter_ext;
   assign num_gb = (four_i > max_ext) ? ((gb_diff << CHAN_BITS) - gb_diff) : '0;

   mep_divider #(
      .DW(DW)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .num_a(num_red),
      .den_a(max_ext),
      .num_b(num_gb),
      .den_b(max_ext << 2),
      .quo_a(red),
      .quo_b(gb),
      .done(div_done)
   );

   assign color_in = inside_ff ? '0 : {ALPHA_OPAQUE, gb, gb, red};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff <= pixel_x;
         py_ff <= pixel_y;
      end
      if (cmd.map_mul) begin
         mx_ff <= mx_in;
         my_ff <= my_in;
      end
      if (cmd.map_add) begin
         cr_ff <= cr_in;
         ci_ff <= ci_in;
      end
      if (cmd.square) begin
         srr_ff <= p_rr >>> FRAC_BITS;
         sii_ff <= p_ii >>> FRAC_BITS;
         sri_ff <= p_ri >>> FRAC_BITS;
      end
      if (cmd.div_start) begin
         inside_ff <= (iter_ff == iter_cap);
      end
      if (cmd.out_load) begin
         out_x_ff <= px_ff;
         out_y_ff <= py_ff;
         iter_out_ff <= iter_ff;
         inside_out_ff <= inside_ff;
         color_ff <= color_in;
      end
      zr_ff <= zr_in;
      zi_ff <= zi_in;
      iter_ff <= iter_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.iter_done = (sum_sq > BAIL) || (iter_ff == iter_cap);
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign out_x = out_x_ff;
   assign out_y = out_y_ff;
   assign iterations = iter_out_ff;
   assign inside_res = inside_out_ff;
   assign pixel_color = color_ff;

endmodule

`default_nettype wire

// File: rtl/mep_ctrl.sv
// controller: sequences mapping, iteration, colour division and output load
`default_nettype none

module mep_ctrl
   import mep_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MAP_MUL;
            end
         end
         ST_MAP_MUL: begin
            cmd.map_mul = 1'b1;
            state_in = ST_MAP_ADD;
         end
         ST_MAP_ADD: begin
            cmd.map_add = 1'b1;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (status.iter_done) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/mep_checker.sv
// port-level checks of the pixel engine result channel, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module mep_checker
   import mep_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int ITER_BITS = 10,
   localparam int OUT_W = 2 * COORD_BITS + ITER_BITS + 1 + COLOR_BITS,
   localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [OUT_TW-1:0] rsp_tdata
);

   localparam int IT_LO = 2 * COORD_BITS;
   localparam int INS = IT_LO + ITER_BITS;
   localparam int COL = INS + 1;

   logic in_set;
   logic [ITER_BITS-1:0] iter;
   logic [COLOR_BITS-1:0] color;

   assign in_set = rsp_tdata[INS];
   assign iter = rsp_tdata[INS-1:IT_LO];
   assign color = rsp_tdata[COL+COLOR_BITS-1:COL];

   `ASSERT_CLK(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")
   `ASSERT_CLK(a_inside_black, rsp_tvalid && in_set |-> color == '0, "inside pixel has nonzero colour")
   `ASSERT_CLK(a_outside_color, rsp_tvalid && !in_set |-> color[31:24] == ALPHA_OPAQUE && color[23:16] == color[15:8] && iter != '0, "escaped pixel colour malformed")
   `ASSERT_CLK_NORST(a_reset_idle, reset |=> !rsp_tvalid, "result valid after reset")

endmodule

bind mandelbrot_escape_time_pixel mep_checker #(
   .COORD_BITS(COORD_BITS),
   .ITER_BITS(ITER_BITS)
) u_mep_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

`default_nettype wire

// File: sim/tb_top.sv
// testbench for the mandelbrot escape-time pixel engine: fixed-point predictor and stream checks
module tb_top;
   import mep_pkg::*;

   localparam int PIX_W = 12;
   localparam int FRAC_W = 27;
   localparam int ITER_W = 10;
   localparam int IN_TW = ((2 * PIX_W + 7) / 8) * 8;
   localparam int OUT_W = 2 * PIX_W + ITER_W + 1 + COLOR_BITS;
   localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
   localparam int PIX_MAX = (1 << PIX_W) - 1;
   localparam int ITER_MAX = (1 << ITER_W) - 1;
   localparam longint BAILOUT = longint'(4) << FRAC_W;
   localparam int ONE_Q = 1 << FRAC_W;
   localparam int RANDOM_ITEMS = 1700;
   localparam int IDLE_PCT = 32;
   localparam int SHOW_MAX = 10;

   typedef struct packed {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
   } pixel_type;

   typedef struct packed {
      logic [PIX_W-1:0]      x;
      logic [PIX_W-1:0]      y;
      logic [ITER_W-1:0]     iter;
      logic                  in_set;
      logic [COLOR_BITS-1:0] color;
   } escape_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // pixel_x, pixel_y
   logic [IN_TW-1:0]         req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // out_x, out_y, iterations, inside_res, pixel_color
   logic [OUT_TW-1:0]        rsp_tdata;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   logic [COORD_REG_BITS-1:0] x_origin = X_START_RST;
   logic [COORD_REG_BITS-1:0] x_pitch = X_STEP_RST;
   logic [COORD_REG_BITS-1:0] y_origin = Y_START_RST;
   logic [COORD_REG_BITS-1:0] y_pitch = Y_STEP_RST;
   logic [ITER_W-1:0]         iter_limit = ITER_W'(ITER_CAP_RST);

   pixel_type  pixel_q[$];
   escape_type escape_q[$];
   pixel_type  held_pix;
   int      pixels_queued = 0;
   int      pixels_returned = 0;
   int      mismatch_count = 0;
   longint  cycle_count = 0;
   longint  cycle_limit = 20000;
   logic    steady = 1'b0;

   mandelbrot_escape_time_pixel #(
      .COORD_BITS(PIX_W),
      .FRAC_BITS (FRAC_W),
      .ITER_BITS (ITER_W)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // exact product, floor shift
   function automatic longint q_mul(longint a, longint b);
      logic signed [127:0] wa, wb, p;
      wa = a;
      wb = b;
      p = wa * wb;
      return longint'(p >>> FRAC_W);
   endfunction

   function automatic longint map_axis(logic [31:0] start, logic [31:0] pitch,
                                       logic [PIX_W-1:0] pix);
      longint v;
      v = longint'($signed(start)) + longint'($signed(pitch)) * longint'(pix);
      if (v > longint'($signed(SAT_MAX))) v = longint'($signed(SAT_MAX));
      if (v < longint'($signed(SAT_MIN))) v = longint'($signed(SAT_MIN));
      return v;
   endfunction

   function automatic escape_type escape_time(pixel_type pix);
      longint cr, ci, zr, zi, nr, ni;
      int unsigned n, lim;
      logic gone;
      logic [CHAN_BITS-1:0] red, gb;
      escape_type r;
      cr = map_axis(x_origin, x_pitch, pix.x);
      ci = map_axis(y_origin, y_pitch, pix.y);
      lim = iter_limit;
      zr = 0;
      zi = 0;
      n = 0;
      gone = 1'b0;
      while (!gone && n < lim) begin
         nr = q_mul(zr, zr) - q_mul(zi, zi) + cr;
         ni = 2 * q_mul(zr, zi) + ci;
         zr = nr;
         zi = ni;
         n++;
         gone = (q_mul(zr, zr) + q_mul(zi, zi)) > BAILOUT;
      end
      r.x = pix.x;
      r.y = pix.y;
      r.iter = ITER_W'(n);
      r.in_set = (n == lim);
      if (r.in_set) begin
         r.color = '0;
      end else begin
         red = CHAN_BITS'((n * 255) / lim);
         gb = (4 * n > lim) ? CHAN_BITS'(((4 * n - lim) * 255) / (4 * lim)) : '0;
         r.color = {ALPHA_OPAQUE, gb, gb, red};
      end
      return r;
   endfunction

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) escape_q.push_back(escape_time(held_pix));
         if (!req_tvalid || req_tready) begin
            if (pixel_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               held_pix = pixel_q.pop_front();
               req_tdata <= {held_pix.y, held_pix.x};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      escape_type want, got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            pixels_returned++;
            got = rsp_tdata[OUT_W-1:0];
            got.x = rsp_tdata[PIX_W-1:0];
            got.y = rsp_tdata[2*PIX_W-1:PIX_W];
            got.iter = rsp_tdata[2*PIX_W+ITER_W-1:2*PIX_W];
            got.in_set = rsp_tdata[2*PIX_W+ITER_W];
            got.color = rsp_tdata[OUT_W-1:2*PIX_W+ITER_W+1];
            if (escape_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_MAX)
                  $display("unexpected word: x=%0d y=%0d it=%0d in=%0d col=%h",
                           got.x, got.y, got.iter, got.in_set, got.color);
            end else begin
               want = escape_q.pop_front();
               if (got.x !== want.x || got.y !== want.y || got.iter !== want.iter ||
                   got.in_set !== want.in_set || got.color !== want.color) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOW_MAX)
                     $display("mismatch: exp x=%0d y=%0d it=%0d in=%0d col=%h, %s",
                              want.x, want.y, want.iter, want.in_set, want.color,
                              $sformatf("got x=%0d y=%0d it=%0d in=%0d col=%h",
                                        got.x, got.y, got.iter, got.in_set, got.color));
               end
            end
         end
         rsp_tready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("** mandelbrot_escape_time_pixel: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_X_START:  x_origin = val;
         CSR_X_STEP:   x_pitch = val;
         CSR_Y_START:  y_origin = val;
         CSR_Y_STEP:   y_pitch = val;
         CSR_ITER_CAP: iter_limit = val[ITER_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_pixel(input int px, input int py);
      pixel_type pix;
      pix.x = PIX_W'(px);
      pix.y = PIX_W'(py);
      pixel_q.push_back(pix);
      pixels_queued++;
      cycle_limit += 4 * (2 * longint'(iter_limit) + 14) + 400;
   endtask

   task automatic drain();
      while (pixels_returned != pixels_queued) @(posedge clock);
   endtask

   // view 4096 pixels wide and high centered on (cx, cy)
   task automatic write_view(input int cx, input int cy);
      int sx, sy;
      sx = int'($urandom_range(16, 131072));
      sy = int'($urandom_range(16, 131072));
      if ($urandom_range(1)) sx = -sx;
      if ($urandom_range(1)) sy = -sy;
      write_reg(CSR_X_START, cx - sx * 2048);
      write_reg(CSR_X_STEP, sx);
      write_reg(CSR_Y_START, cy - sy * 2048);
      write_reg(CSR_Y_STEP, sy);
   endtask

   initial begin
      int kind, cnt, random_count;
      random_count = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default view: corners, alternating bits, points inside the set
      queue_pixel(0, 0);
      queue_pixel(PIX_MAX, PIX_MAX);
      queue_pixel(0, PIX_MAX);
      queue_pixel(PIX_MAX, 0);
      queue_pixel(1092, 500);
      queue_pixel(712, 500);
      queue_pixel(2048, 2048);
      queue_pixel(1, 2);
      queue_pixel(2730, 1365);
      drain();

      // single step: escape on the last step counts as inside
      write_reg(CSR_ITER_CAP, 1);
      queue_pixel(0, 0);
      queue_pixel(1092, 500);
      queue_pixel(PIX_MAX, PIX_MAX);
      drain();

      // masked to a zero limit
      write_reg(CSR_ITER_CAP, 32'hFFFF_FC00);
      queue_pixel(1092, 500);
      queue_pixel(PIX_MAX, 0);
      drain();

      // unused indexes, then saturating extremes
      for (int k = int'(CSR_ITER_CAP) + 1; k < (1 << CSR_ADDR_BITS); k++)
         write_reg(k[CSR_ADDR_BITS-1:0], $urandom());
      write_reg(CSR_X_START, SAT_MIN);
      write_reg(CSR_X_STEP, SAT_MAX);
      write_reg(CSR_Y_START, SAT_MAX);
      write_reg(CSR_Y_STEP, SAT_MIN);
      write_reg(CSR_ITER_CAP, ITER_MAX);
      queue_pixel(0, 0);
      queue_pixel(PIX_MAX, PIX_MAX);
      queue_pixel(1, 1);
      drain();

      // full limit on points inside the set
      write_reg(CSR_X_START, X_START_RST);
      write_reg(CSR_X_STEP, X_STEP_RST);
      write_reg(CSR_Y_START, Y_START_RST);
      write_reg(CSR_Y_STEP, Y_STEP_RST);
      queue_pixel(1092, 500);
      queue_pixel(712, 500);
      drain();

      for (int p = 0; random_count < RANDOM_ITEMS; p++) begin
         kind = (p % 5 == 4) ? 2 : (p % 5 == 2) ? 1 : 0;
         if (kind == 1) begin
            write_reg(CSR_X_START, $urandom());
            write_reg(CSR_X_STEP, $urandom());
            write_reg(CSR_Y_START, $urandom());
            write_reg(CSR_Y_STEP, $urandom());
            write_reg(CSR_ITER_CAP, $urandom_range(1, ITER_MAX));
            cnt = 100;
         end else begin
            write_view(int'($urandom_range(0, 2 * ONE_Q)) - 7 * ONE_Q / 4,
                       int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
            if (kind == 2) begin
               write_reg(CSR_ITER_CAP, $urandom_range(200, ITER_MAX));
               cnt = 12;
            end else begin
               write_reg(CSR_ITER_CAP, $urandom_range(3) == 0 ? $urandom_range(1, 16)
                                                               : $urandom_range(1, 100));
               cnt = 150;
            end
         end
         steady = (p == 1);
         repeat (cnt) queue_pixel($urandom_range(PIX_MAX), $urandom_range(PIX_MAX));
         random_count += cnt;
         drain();
      end
      steady = 1'b0;

      repeat (2 * int'(iter_limit) + 30) @(posedge clock);
      if (mismatch_count == 0 && escape_q.size() == 0) begin
         $display("** mandelbrot_escape_time_pixel: PASSED **");
      end else begin
         $display("** mandelbrot_escape_time_pixel: FAILED **");
      end
      $finish;
   end

endmodule
